// ----- hdl/tfpt_pkg.sv -----
// ---------------------------------------------------------------------------
// tfpt_pkg
// shared types and constants for the fifo page translator
// ---------------------------------------------------------------------------
package tfpt_pkg;

	localparam int TLB_DEPTH  = 16;
	localparam int PAGE_COUNT = 256;
	localparam int PAGE_W     = 8;
	localparam int FRAME_W    = 8;
	localparam int OFFSET_W   = 8;
	localparam int ADDR_W     = PAGE_W + OFFSET_W;
	localparam int CNT_W      = $clog2(TLB_DEPTH + 1);
	localparam int CFG_W      = 5;
	localparam int CAP_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int PADDR_W    = 3;

	localparam logic [CFG_W-1:0] TLB_ENTRIES_RESET = CFG_W'(16);
	localparam logic [0:0]       REG_TLB_ENTRIES   = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_DECIDE,
		ST_APPEND
	} state_t;

	typedef struct packed {
		logic               shift;
		logic [PAGE_W-1:0]  page;
		logic [FRAME_W-1:0] frame;
	} chain_ctrl_t;

	typedef struct packed {
		logic               map;
		logic [PAGE_W-1:0]  page;
		logic [FRAME_W-1:0] frame;
		logic               clr;
		logic [PAGE_W-1:0]  clr_page;
	} tbl_upd_t;

endpackage

// ----- hdl/tfpt_cell.sv -----
// ---------------------------------------------------------------------------
// tfpt_cell
// one translation buffer entry: holds a page and frame, compares the page
// ---------------------------------------------------------------------------
module tfpt_cell (
	input  logic                          clk,
	input  logic                          shift,
	input  logic [tfpt_pkg::PAGE_W-1:0]   prev_page,
	input  logic [tfpt_pkg::FRAME_W-1:0]  prev_frame,
	input  logic [tfpt_pkg::PAGE_W-1:0]   look_page,
	input  logic                          active,
	output logic [tfpt_pkg::PAGE_W-1:0]   page,
	output logic [tfpt_pkg::FRAME_W-1:0]  frame,
	output logic                          hit,
	output logic [tfpt_pkg::FRAME_W-1:0]  hit_frame
);

	logic [tfpt_pkg::PAGE_W-1:0]  page_q;
	logic [tfpt_pkg::FRAME_W-1:0] frame_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			page_q  <= prev_page;
			frame_q <= prev_frame;
		end
	end

	assign page      = page_q;
	assign frame     = frame_q;
	assign hit       = active && (page_q == look_page);
	assign hit_frame = hit ? frame_q : '0;

endmodule

// ----- hdl/tfpt_chain.sv -----
// ---------------------------------------------------------------------------
// tfpt_chain
// row of buffer cells; newest entry enters at cell 0 and moves up on append
// ---------------------------------------------------------------------------
module tfpt_chain (
	input  logic                         clk,
	input  tfpt_pkg::chain_ctrl_t        ctrl,
	input  logic [tfpt_pkg::CNT_W-1:0]   fill,
	input  logic [tfpt_pkg::PAGE_W-1:0]  look_page,
	output logic                         hit,
	output logic [tfpt_pkg::FRAME_W-1:0] hit_frame
);

	localparam int N = tfpt_pkg::TLB_DEPTH;

	logic [N-1:0]                        cell_hit;
	logic [tfpt_pkg::PAGE_W-1:0]         cell_page  [N];
	logic [tfpt_pkg::FRAME_W-1:0]        cell_frame [N];
	logic [tfpt_pkg::FRAME_W-1:0]        cell_hfr   [N];
	logic [tfpt_pkg::PAGE_W-1:0]         in_page    [N];
	logic [tfpt_pkg::FRAME_W-1:0]        in_frame   [N];

	for (genvar k = 0; k < N; k++) begin : g_cell
		if (k == 0) begin : g_head
			assign in_page[k]  = ctrl.page;
			assign in_frame[k] = ctrl.frame;
		end else begin : g_body
			assign in_page[k]  = cell_page[k-1];
			assign in_frame[k] = cell_frame[k-1];
		end

		tfpt_cell u_cell (
			.clk       (clk),
			.shift     (ctrl.shift),
			.prev_page (in_page[k]),
			.prev_frame(in_frame[k]),
			.look_page (look_page),
			.active    (tfpt_pkg::CNT_W'(k) < fill),
			.page      (cell_page[k]),
			.frame     (cell_frame[k]),
			.hit       (cell_hit[k]),
			.hit_frame (cell_hfr[k])
		);
	end

	// a page sits in the buffer at most once, so the matches can be merged
	always_comb begin
		hit_frame = '0;
		for (int k = 0; k < N; k++) begin
			hit_frame = hit_frame | cell_hfr[k];
		end
	end

	assign hit = |cell_hit;

endmodule

// ----- hdl/tfpt_table.sv -----
// ---------------------------------------------------------------------------
// tfpt_table
// page table with per-page valid bits and a frame-to-page owner memory
// ---------------------------------------------------------------------------
module tfpt_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [tfpt_pkg::PAGE_W-1:0]  rd_page,
	input  logic [tfpt_pkg::FRAME_W-1:0] rd_owner,
	input  tfpt_pkg::tbl_upd_t           upd,
	output logic                         page_valid,
	output logic [tfpt_pkg::FRAME_W-1:0] page_frame,
	output logic [tfpt_pkg::PAGE_W-1:0]  owner_page
);

	localparam int PN = tfpt_pkg::PAGE_COUNT;
	localparam int FN = 1 << tfpt_pkg::FRAME_W;

	logic [PN-1:0]                valid_q;
	logic [tfpt_pkg::FRAME_W-1:0] frame_mem [PN];
	logic [tfpt_pkg::PAGE_W-1:0]  owner_mem [FN];
	logic                         valid_rd_q;
	logic [tfpt_pkg::FRAME_W-1:0] frame_rd_q;
	logic [tfpt_pkg::PAGE_W-1:0]  owner_rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (upd.clr) begin
				valid_q[upd.clr_page] <= 1'b0;
			end
			if (upd.map) begin
				valid_q[upd.page] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.map) begin
			frame_mem[upd.page]  <= upd.frame;
			owner_mem[upd.frame] <= upd.page;
		end
		valid_rd_q <= valid_q[rd_page];
		frame_rd_q <= frame_mem[rd_page];
		owner_rd_q <= owner_mem[rd_owner];
	end

	assign page_valid = valid_rd_q;
	assign page_frame = frame_rd_q;
	assign owner_page = owner_rd_q;

endmodule

// ----- hdl/tlb_fifo_page_translator_top.sv -----
// ---------------------------------------------------------------------------
// tlb_fifo_page_translator_top
// logical to physical address translation with fifo buffer and page table
// ---------------------------------------------------------------------------
// An address is accepted when start is high and busy is low; its result is
// shown for exactly one cycle with done high and cannot be held off. A
// buffer hit passes through accept, cell compare and decision; a miss adds
// an append step, plus one more per evicted buffer entry. The path is set
// by the compare across the cell row, the registered page table read and
// the append step that shifts the row. A new address may be accepted in
// the cycle that its predecessor's result is shown. The user must write
// tlb_entries through the register port only while the block is idle; the
// block does not enforce this. There is no clearing pass after reset.
module tlb_fifo_page_translator_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [tfpt_pkg::PADDR_W-1:0]        paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	input  logic                                start,
	output logic                                busy,
	input  logic [tfpt_pkg::ADDR_W-1:0]         logical_address,
	output logic                                done,
	output logic [tfpt_pkg::PAGE_W-1:0]         page_number,
	output logic [tfpt_pkg::OFFSET_W-1:0]       page_offset,
	output logic [tfpt_pkg::FRAME_W-1:0]        frame_number,
	output logic [tfpt_pkg::ADDR_W-1:0]         physical_address,
	output logic                                tlb_hit,
	output logic                                page_fault
);

	tfpt_pkg::state_t                state_q, state_nxt;
	logic [tfpt_pkg::CFG_W-1:0]      tlb_entries_q;
	logic [tfpt_pkg::ADDR_W-1:0]     addr_q;
	logic [tfpt_pkg::CNT_W-1:0]      fill_q;
	logic [tfpt_pkg::FRAME_W-1:0]    nfree_q;
	logic                            wrapped_q;
	logic                            hit_q;
	logic [tfpt_pkg::FRAME_W-1:0]    hit_frame_q;
	logic [tfpt_pkg::FRAME_W-1:0]    sel_frame_q;
	logic                            fault_q;
	logic                            done_q;
	logic [tfpt_pkg::ADDR_W-1:0]     res_addr_q;
	logic [tfpt_pkg::FRAME_W-1:0]    res_frame_q;
	logic                            res_hit_q;
	logic                            res_fault_q;

	logic                            wr_en;
	logic                            accept;
	logic                            emit;
	logic                            evict_need;
	logic                            miss_fault;
	logic [tfpt_pkg::CAP_W-1:0]      cfg_ext;
	logic [tfpt_pkg::CNT_W-1:0]      cap;
	logic [tfpt_pkg::PAGE_W-1:0]     cur_page;
	logic                            chain_hit;
	logic [tfpt_pkg::FRAME_W-1:0]    chain_frame;
	logic                            tbl_valid;
	logic [tfpt_pkg::FRAME_W-1:0]    tbl_frame;
	logic [tfpt_pkg::PAGE_W-1:0]     owner_page;
	tfpt_pkg::chain_ctrl_t           chain_ctrl;
	tfpt_pkg::tbl_upd_t              tbl_upd;

	// register port
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready
	                && (paddr[2] == tfpt_pkg::REG_TLB_ENTRIES);
	assign prdata = (paddr[2] == tfpt_pkg::REG_TLB_ENTRIES)
	                ? 32'(tlb_entries_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tlb_entries_q <= tfpt_pkg::TLB_ENTRIES_RESET;
		end else if (wr_en) begin
			tlb_entries_q <= pwdata[tfpt_pkg::CFG_W-1:0];
		end
	end

	// effective capacity
	always_comb begin
		cfg_ext = tfpt_pkg::CAP_W'(tlb_entries_q);
		if (cfg_ext == '0) begin
			cap = tfpt_pkg::CNT_W'(1);
		end else if (cfg_ext > tfpt_pkg::CAP_W'(tfpt_pkg::TLB_DEPTH)) begin
			cap = tfpt_pkg::CNT_W'(tfpt_pkg::TLB_DEPTH);
		end else begin
			cap = tfpt_pkg::CNT_W'(cfg_ext);
		end
	end

	assign cur_page   = addr_q[tfpt_pkg::ADDR_W-1:tfpt_pkg::OFFSET_W];
	assign evict_need = fill_q >= cap;
	assign accept     = start && !busy;

	tfpt_chain u_chain (
		.clk      (clk),
		.ctrl     (chain_ctrl),
		.fill     (fill_q),
		.look_page(cur_page),
		.hit      (chain_hit),
		.hit_frame(chain_frame)
	);

	tfpt_table u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_page   (cur_page),
		.rd_owner  (nfree_q),
		.upd       (tbl_upd),
		.page_valid(tbl_valid),
		.page_frame(tbl_frame),
		.owner_page(owner_page)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			tfpt_pkg::ST_IDLE: begin
				if (start) state_nxt = tfpt_pkg::ST_LOOKUP;
			end
			tfpt_pkg::ST_LOOKUP: begin
				state_nxt = tfpt_pkg::ST_DECIDE;
			end
			tfpt_pkg::ST_DECIDE: begin
				state_nxt = hit_q ? tfpt_pkg::ST_IDLE : tfpt_pkg::ST_APPEND;
			end
			tfpt_pkg::ST_APPEND: begin
				if (!evict_need) state_nxt = tfpt_pkg::ST_IDLE;
			end
			default: state_nxt = tfpt_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		busy       = 1'b1;
		emit       = 1'b0;
		miss_fault = 1'b0;
		unique case (state_q)
			tfpt_pkg::ST_IDLE: begin
				busy = 1'b0;
			end
			tfpt_pkg::ST_LOOKUP: begin
			end
			tfpt_pkg::ST_DECIDE: begin
				emit       = hit_q;
				miss_fault = !hit_q && !tbl_valid;
			end
			tfpt_pkg::ST_APPEND: begin
				emit = !evict_need;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_comb begin
		chain_ctrl.shift = (state_q == tfpt_pkg::ST_APPEND) && !evict_need;
		chain_ctrl.page  = cur_page;
		chain_ctrl.frame = sel_frame_q;

		// remap on a fault; the page that held the frame before loses it
		tbl_upd.map      = miss_fault;
		tbl_upd.page     = cur_page;
		tbl_upd.frame    = nfree_q;
		tbl_upd.clr      = miss_fault && wrapped_q;
		tbl_upd.clr_page = owner_page;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tfpt_pkg::ST_IDLE;
			fill_q    <= '0;
			nfree_q   <= '0;
			wrapped_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= emit;
			if (state_q == tfpt_pkg::ST_APPEND) begin
				if (evict_need) begin
					fill_q <= fill_q - tfpt_pkg::CNT_W'(1);
				end else begin
					fill_q <= fill_q + tfpt_pkg::CNT_W'(1);
				end
			end
			if (miss_fault) begin
				nfree_q <= nfree_q + tfpt_pkg::FRAME_W'(1);
				if (nfree_q == '1) begin
					wrapped_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= logical_address;
		end
		if (state_q == tfpt_pkg::ST_LOOKUP) begin
			hit_q       <= chain_hit;
			hit_frame_q <= chain_frame;
		end
		if (state_q == tfpt_pkg::ST_DECIDE) begin
			sel_frame_q <= tbl_valid ? tbl_frame : nfree_q;
			fault_q     <= !tbl_valid;
		end
		if (emit) begin
			res_addr_q  <= addr_q;
			res_hit_q   <= (state_q == tfpt_pkg::ST_DECIDE);
			res_fault_q <= (state_q == tfpt_pkg::ST_APPEND) && fault_q;
			res_frame_q <= (state_q == tfpt_pkg::ST_DECIDE) ? hit_frame_q : sel_frame_q;
		end
	end

	assign done             = done_q;
	assign page_number      = res_addr_q[tfpt_pkg::ADDR_W-1:tfpt_pkg::OFFSET_W];
	assign page_offset      = res_addr_q[tfpt_pkg::OFFSET_W-1:0];
	assign frame_number     = res_frame_q;
	assign physical_address = {res_frame_q, res_addr_q[tfpt_pkg::OFFSET_W-1:0]};
	assign tlb_hit          = res_hit_q;
	assign page_fault       = res_fault_q;

	// checks
	a_hit_fault_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(tlb_hit && page_fault))
		else $error("hit and fault flagged together");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= tfpt_pkg::CNT_W'(tfpt_pkg::TLB_DEPTH))
		else $error("buffer fill beyond depth");

	a_idle_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("sequencer idle without a result transfer");

	a_done_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result transfer without work in progress");

endmodule

// ----- tb/tlb_fifo_page_translator_top_test.sv -----
// ---------------------------------------------------------------------------
// tlb_fifo_page_translator_top_test
// self-checking bench for the fifo buffer page translator
// ---------------------------------------------------------------------------
// Addresses are sent over the start/busy handshake with random gaps. Each
// accepted address is run through a local copy of the buffer, page table and
// frame allocator, and the expected translation is queued. Every done strobe
// is compared field by field against the oldest queued translation. The
// buffer capacity is rewritten over the register port between bursts while
// the block is idle, covering zero, one, the full depth and values above it.
// ---------------------------------------------------------------------------

typedef struct packed {
	logic [tfpt_pkg::PAGE_W-1:0]   page;
	logic [tfpt_pkg::OFFSET_W-1:0] offset;
	logic [tfpt_pkg::FRAME_W-1:0]  frame;
	logic [tfpt_pkg::ADDR_W-1:0]   phys;
	logic                          hit;
	logic                          fault;
} xlat_t;

class page_xlat_checker;
	bit [tfpt_pkg::PAGE_W-1:0]  tlb_page [tfpt_pkg::TLB_DEPTH];
	bit [tfpt_pkg::FRAME_W-1:0] tlb_frame [tfpt_pkg::TLB_DEPTH];
	int unsigned                tlb_fill;
	int unsigned                tlb_oldest;
	bit [tfpt_pkg::FRAME_W-1:0] pt_frame [tfpt_pkg::PAGE_COUNT];
	bit                         pt_valid [tfpt_pkg::PAGE_COUNT];
	bit [tfpt_pkg::FRAME_W-1:0] next_frame;
	bit [tfpt_pkg::CFG_W-1:0]   tlb_entries;
	xlat_t                      pending [$];
	int errors, checked, hits, stale_hits, faults, reloads;

	function new();
		tlb_entries = tfpt_pkg::TLB_ENTRIES_RESET;
		tlb_fill    = 0;
		tlb_oldest  = 0;
		next_frame  = '0;
		foreach (pt_valid[i]) begin
			pt_valid[i] = 1'b0;
			pt_frame[i] = '0;
		end
	endfunction

	function void report(string msg);
		errors++;
		if (errors <= 40)
			$display("[%0t] error: %s", $time, msg);
	endfunction

	function void write_reg(int idx, bit [31:0] value);
		if (idx == int'(tfpt_pkg::REG_TLB_ENTRIES))
			tlb_entries = value[tfpt_pkg::CFG_W-1:0];
	endfunction

	function int unsigned capacity();
		int unsigned c;
		c = tlb_entries;
		if (c < 1)
			c = 1;
		if (c > tfpt_pkg::TLB_DEPTH)
			c = tfpt_pkg::TLB_DEPTH;
		return c;
	endfunction

	// evict oldest until below capacity, then push at the tail
	function void tlb_push(bit [tfpt_pkg::PAGE_W-1:0] page, bit [tfpt_pkg::FRAME_W-1:0] frame);
		int unsigned cap;
		int unsigned slot;
		cap = capacity();
		while (tlb_fill >= cap && tlb_fill > 0) begin
			tlb_oldest = (tlb_oldest + 1) % tfpt_pkg::TLB_DEPTH;
			tlb_fill--;
		end
		slot = (tlb_oldest + tlb_fill) % tfpt_pkg::TLB_DEPTH;
		tlb_page[slot]  = page;
		tlb_frame[slot] = frame;
		tlb_fill++;
	endfunction

	function void note_address(bit [tfpt_pkg::ADDR_W-1:0] addr);
		xlat_t       x;
		int unsigned k;
		int unsigned idx;
		x.page   = addr[15:8];
		x.offset = addr[7:0];
		x.frame  = '0;
		x.hit    = 1'b0;
		x.fault  = 1'b0;
		for (k = 0; k < tlb_fill; k++) begin
			idx = (tlb_oldest + k) % tfpt_pkg::TLB_DEPTH;
			if (!x.hit && tlb_page[idx] == x.page) begin
				x.frame = tlb_frame[idx];
				x.hit   = 1'b1;
			end
		end
		if (x.hit) begin
			hits++;
			if (!pt_valid[x.page] || pt_frame[x.page] != x.frame)
				stale_hits++;
		end else if (pt_valid[x.page]) begin
			x.frame = pt_frame[x.page];
			tlb_push(x.page, x.frame);
			reloads++;
		end else begin
			x.fault = 1'b1;
			x.frame = next_frame;
			tlb_push(x.page, x.frame);
			foreach (pt_frame[i])
				if (pt_frame[i] == x.frame)
					pt_valid[i] = 1'b0;
			pt_frame[x.page] = x.frame;
			pt_valid[x.page] = 1'b1;
			next_frame++;
			faults++;
		end
		x.phys = {x.frame, x.offset};
		pending.insert(pending.size(), x);
	endfunction

	function void check_xlat(xlat_t got);
		xlat_t exp;
		if (pending.size() == 0) begin
			report($sformatf("result with nothing outstanding, page %0h", got.page));
			return;
		end
		exp = pending[0];
		pending.delete(0);
		checked++;
		if (got.page !== exp.page)
			report($sformatf("page_number %h, expected %h", got.page, exp.page));
		if (got.offset !== exp.offset)
			report($sformatf("page_offset %h, expected %h", got.offset, exp.offset));
		if (got.frame !== exp.frame)
			report($sformatf("frame_number %h, expected %h (page %h)", got.frame, exp.frame,
				exp.page));
		if (got.phys !== exp.phys)
			report($sformatf("physical_address %h, expected %h", got.phys, exp.phys));
		if (got.hit !== exp.hit)
			report($sformatf("tlb_hit %b, expected %b (page %h)", got.hit, exp.hit, exp.page));
		if (got.fault !== exp.fault)
			report($sformatf("page_fault %b, expected %b (page %h)", got.fault, exp.fault,
				exp.page));
	endfunction
endclass

module tlb_fifo_page_translator_top_test;

	localparam int UNUSED_REG    = 1;
	localparam int SETTLE_CYCLES = tfpt_pkg::TLB_DEPTH + 8;

	logic                            clk;
	logic                            arst_n          = 1'b0;
	logic                            psel            = 1'b0;
	logic                            penable         = 1'b0;
	logic                            pwrite          = 1'b0;
	logic [tfpt_pkg::PADDR_W-1:0]    paddr           = '0;
	logic [31:0]                     pwdata          = '0;
	logic [31:0]                     prdata;
	logic                            pready;
	logic                            start           = 1'b0;
	logic                            busy;
	logic [tfpt_pkg::ADDR_W-1:0]     logical_address = '0;
	logic                            done;
	logic [tfpt_pkg::PAGE_W-1:0]     page_number;
	logic [tfpt_pkg::OFFSET_W-1:0]   page_offset;
	logic [tfpt_pkg::FRAME_W-1:0]    frame_number;
	logic [tfpt_pkg::ADDR_W-1:0]     physical_address;
	logic                            tlb_hit;
	logic                            page_fault;

	page_xlat_checker                xlat_chk;
	bit [tfpt_pkg::PAGE_W-1:0]       working_pages [$];
	int                              reg_writes;

	tlb_fifo_page_translator_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.start            (start),
		.busy             (busy),
		.logical_address  (logical_address),
		.done             (done),
		.page_number      (page_number),
		.page_offset      (page_offset),
		.frame_number     (frame_number),
		.physical_address (physical_address),
		.tlb_hit          (tlb_hit),
		.page_fault       (page_fault)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		xlat_t got;
		if (arst_n && done !== 1'b0) begin
			got.page  = page_number;
			got.offset = page_offset;
			got.frame = frame_number;
			got.phys  = physical_address;
			got.hit   = tlb_hit;
			got.fault = page_fault;
			xlat_chk.check_xlat(got);
		end
	end

	task automatic reg_access(input int idx, input bit wr, input bit [31:0] wdata,
			output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= tfpt_pkg::PADDR_W'(4 * idx);
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_reg(input int idx, input bit [tfpt_pkg::CFG_W-1:0] value);
		logic [31:0] rdata;
		bit   [31:0] wdata;
		wdata = {(32 - tfpt_pkg::CFG_W)'($urandom), value};
		reg_access(idx, 1'b1, wdata, rdata);
		xlat_chk.write_reg(idx, wdata);
		reg_writes++;
		reg_access(int'(tfpt_pkg::REG_TLB_ENTRIES), 1'b0, '0, rdata);
		if (rdata !== {{(32-tfpt_pkg::CFG_W){1'b0}}, xlat_chk.tlb_entries})
			xlat_chk.report($sformatf("tlb_entries reads %h, expected %h", rdata,
				xlat_chk.tlb_entries));
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	task automatic send_address(input bit [tfpt_pkg::ADDR_W-1:0] addr, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start           <= 1'b1;
		logical_address <= addr;
		do @(posedge clk); while (busy !== 1'b0);
		xlat_chk.note_address(addr);
	endtask

	// stop sending and let every outstanding transfer come back
	task automatic drain();
		start <= 1'b0;
		while (xlat_chk.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
	endtask

	task automatic send_list(input bit [tfpt_pkg::ADDR_W-1:0] addrs [$]);
		foreach (addrs[i])
			send_address(addrs[i], gap_len());
		drain();
	endtask

	function automatic bit [tfpt_pkg::ADDR_W-1:0] pick_address();
		bit [tfpt_pkg::PAGE_W-1:0] page;
		if (working_pages.size() != 0 && $urandom_range(99) < 65)
			page = working_pages[$urandom_range(working_pages.size() - 1)];
		else
			page = tfpt_pkg::PAGE_W'($urandom);
		return {page, 8'($urandom)};
	endfunction

	task automatic random_burst(input int n_items);
		int ws_size;
		bit calm;
		ws_size = xlat_chk.capacity() + $urandom_range(8);
		working_pages.delete();
		repeat (ws_size)
			working_pages.insert(working_pages.size(), tfpt_pkg::PAGE_W'($urandom));
		calm = ($urandom_range(3) == 0);
		repeat (n_items) send_address(pick_address(), calm ? 0 : gap_len());
		drain();
	endtask

	initial begin
		bit [tfpt_pkg::CFG_W-1:0] caps [$];
		xlat_chk   = new();
		reg_writes = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// cold start at reset capacity: first faults, extremes, repeat hits
		send_list('{16'h0000, 16'h00FF, 16'hFFFF, 16'hFF00, 16'h1234, 16'hA5A5,
			16'h5A5A, 16'h12CD, 16'h8001, 16'h7FFE});

		// capacity zero with seven buffered entries: old entries still hit until next push
		set_reg(int'(tfpt_pkg::REG_TLB_ENTRIES), '0);
		send_list('{16'h00AA, 16'h0101, 16'h0102, 16'h0055, 16'h0101});

		// above depth, and a write to an unused register
		set_reg(int'(tfpt_pkg::REG_TLB_ENTRIES), tfpt_pkg::CFG_W'(31));
		set_reg(UNUSED_REG, tfpt_pkg::CFG_W'(1));
		send_list('{16'hFFAA, 16'h1234, 16'hFF00, 16'hA5FF});

		caps = '{tfpt_pkg::CFG_W'(16), tfpt_pkg::CFG_W'(1), tfpt_pkg::CFG_W'(0),
			tfpt_pkg::CFG_W'(31), tfpt_pkg::CFG_W'(2), tfpt_pkg::CFG_W'(8),
			tfpt_pkg::CFG_W'(17), tfpt_pkg::CFG_W'(5), tfpt_pkg::CFG_W'(12),
			tfpt_pkg::CFG_W'($urandom_range(31))};
		foreach (caps[i]) begin
			set_reg(int'(tfpt_pkg::REG_TLB_ENTRIES), caps[i]);
			random_burst(120);
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (xlat_chk.pending.size() != 0)
			xlat_chk.report($sformatf("%0d translations never returned",
				xlat_chk.pending.size()));
		$display("%0d translations checked: %0d buffer hits (%0d on stale entries)",
			xlat_chk.checked, xlat_chk.hits, xlat_chk.stale_hits);
		$display("%0d faults, %0d table reloads, %0d register writes, capacities 0 to 31",
			xlat_chk.faults, xlat_chk.reloads, reg_writes);
		if (xlat_chk.errors == 0)
			$display("tlb_fifo_page_translator_top_test passed");
		else
			$display("tlb_fifo_page_translator_top_test failed");
		$finish;
	end

	initial begin
		#4000000;
		$display("timeout waiting for translations");
		$display("tlb_fifo_page_translator_top_test failed");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/tfpt_pkg.sv
hdl/tfpt_cell.sv
hdl/tfpt_chain.sv
hdl/tfpt_table.sv
hdl/tlb_fifo_page_translator_top.sv
tb/tlb_fifo_page_translator_top_test.sv
